// ----- design/assert_macros.svh -----
// Assertion macros for the checker file of the motor hour meter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, masked while reset is asserted.
`define MHM_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("motor hour meter check failed");

// Condition that must never be seen while out of reset.
`define MHM_NEVER(lbl, clk, rst, cond) \
   `MHM_ASSERT(lbl, clk, rst, !(cond))

`endif

// ----- design/mhm_pkg.sv -----
// Constants, types and the divide-by-1000 helper for the motor hour meter.
package mhm_pkg;

   localparam int unsigned TIME_W     = 32;
   localparam int unsigned SEC_W      = 32;
   localparam int unsigned CSR_IDX_W  = 1;
   localparam int unsigned CSR_DATA_W = 32;

   typedef logic [TIME_W-1:0]     time_type;
   typedef logic [SEC_W-1:0]      sec_type;
   typedef logic [CSR_IDX_W-1:0]  csr_idx_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;

   localparam csr_idx_type CSR_STORED_TOTAL = 1'd0;
   localparam csr_idx_type CSR_SAVE_INTERVAL = 1'd1;

   localparam time_type SAVE_INTERVAL_RESET = 32'd60000;

   // n / 1000 for any 32-bit n: ceil(2^38 / 1000) reciprocal, exact over the range
   localparam int unsigned   RECIP_W     = 29;
   localparam int unsigned   RECIP_SHIFT = 38;
   localparam int unsigned   PROD_W      = TIME_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP_1000 = 29'h1062_4DD3;

   function automatic sec_type ms_to_sec(input time_type ms);
      logic [PROD_W-1:0] prod;
      prod = {{RECIP_W{1'b0}}, ms} * {{TIME_W{1'b0}}, RECIP_1000};
      return {{(SEC_W-(PROD_W-RECIP_SHIFT)){1'b0}}, prod[PROD_W-1:RECIP_SHIFT]};
   endfunction

endpackage

// ----- design/motor_hour_meter_unit.sv -----
// Motor hour meter: session timer, run-time total and save requests.
//
// One result beat per request beat, in order. A request is captured in an
// input register; when the result register is free or draining, a single
// pass of logic (three time differences, two reciprocal multiplies for the
// divide by 1000, one 32-bit add and one compare) updates the meter state
// and loads the result register. Throughput is one beat per clock while
// rsp_stall is low. The input register keeps taking a beat while a finished
// result waits under rsp_stall; req_stall rises only when both registers are
// full and the result side is stalled.
//
// Edges of armed and motor_running are taken against the previous beat.
// Arming restarts the session timer; the session seconds hold after
// disarm. A run that ends (motor stop, disarm, or both in one beat) adds
// its whole seconds to the wrapping 32-bit total once and requests a save.
// Disarming with the motor still on restarts run timing at that beat.
// While running, a periodic save is requested once the save interval has
// passed since the last save; save_value is the live total on a strobe
// beat and zero otherwise. All time differences wrap modulo 2^32.
//
// CSR index 0 loads the running total (stored_total_sec); index 1 sets the
// periodic save interval. Write only while the block is idle.
module motor_hour_meter_unit (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  mhm_pkg::time_type     req_time_ms,
   input  logic                  req_armed,
   input  logic                  req_motor_running,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output mhm_pkg::sec_type      rsp_session_sec,
   output mhm_pkg::sec_type      rsp_total_sec,
   output logic                  rsp_save_strobe,
   output mhm_pkg::sec_type      rsp_save_value,
   // configuration
   input  logic                  csr_we,
   input  mhm_pkg::csr_idx_type  csr_index,
   input  mhm_pkg::csr_data_type csr_wdata
);
   import mhm_pkg::*;

   // input register
   logic     in_vld_ff, in_vld_in;
   time_type in_now_ff;
   logic     in_armed_ff, in_run_ff;

   // result register
   logic     out_vld_ff, out_vld_in;
   sec_type  out_sess_ff, out_total_ff, out_value_ff;
   logic     out_strobe_ff;

   // meter state
   logic     prev_armed_ff, prev_armed_in;
   logic     prev_run_ff, prev_run_in;
   time_type sess_start_ff, sess_start_in;
   sec_type  sess_sec_ff, sess_sec_in;
   time_type run_start_ff, run_start_in;
   sec_type  acc_ff, acc_in;
   time_type last_save_ff, last_save_in;
   time_type interval_ff, interval_in;

   logic     req_take, advance;
   logic     arm_edge, disarm_edge, run_rise, end_run, flush, periodic;
   time_type sess_start_cur, run_start_cur, sess_diff, run_diff, save_gap, last_save_cur;
   sec_type  sess_q, run_q, run_sum, live;

   // handshake: stage advances when the result register is free or draining
   assign advance   = in_vld_ff && (!out_vld_ff || !rsp_stall);
   assign req_stall = in_vld_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_vld_in = req_take || (in_vld_ff && !advance);
      if (advance) begin
         out_vld_in = 1'b1;
      end else if (!rsp_stall) begin
         out_vld_in = 1'b0;
      end else begin
         out_vld_in = out_vld_ff;
      end
   end

   // single pass over the captured beat
   always_comb begin
      arm_edge    = in_armed_ff && !prev_armed_ff;
      disarm_edge = !in_armed_ff && prev_armed_ff;
      run_rise    = in_run_ff && !prev_run_ff;

      sess_start_cur = arm_edge ? in_now_ff : sess_start_ff;
      sess_diff      = in_now_ff - sess_start_cur;
      sess_q         = ms_to_sec(sess_diff);

      run_start_cur = run_rise ? in_now_ff : run_start_ff;
      run_diff      = in_now_ff - run_start_cur;
      run_q         = ms_to_sec(run_diff);
      run_sum       = acc_ff + run_q;

      // a stop and a disarm in the same beat close the run once
      end_run = prev_run_ff && (!in_run_ff || disarm_edge);
      flush   = end_run || disarm_edge;

      last_save_cur = flush ? in_now_ff : last_save_ff;
      save_gap      = in_now_ff - last_save_cur;
      periodic      = in_run_ff && (save_gap >= interval_ff);

      // live total equals the flushed total whenever the run was closed
      live = (end_run || in_run_ff) ? run_sum : acc_ff;
   end

   // state next values
   always_comb begin
      prev_armed_in = prev_armed_ff;
      prev_run_in   = prev_run_ff;
      sess_start_in = sess_start_ff;
      sess_sec_in   = sess_sec_ff;
      run_start_in  = run_start_ff;
      acc_in        = acc_ff;
      last_save_in  = last_save_ff;
      interval_in   = interval_ff;

      if (advance) begin
         prev_armed_in = in_armed_ff;
         prev_run_in   = in_run_ff;
         sess_start_in = sess_start_cur;
         if (in_armed_ff) begin
            sess_sec_in = sess_q;
         end
         if (end_run) begin
            acc_in       = run_sum;
            run_start_in = in_run_ff ? in_now_ff : '0;
         end else begin
            run_start_in = run_start_cur;
         end
         last_save_in = periodic ? in_now_ff : last_save_cur;
      end

      if (csr_we) begin
         case (csr_index)
            CSR_STORED_TOTAL: begin
               acc_in = csr_wdata;
            end
            CSR_SAVE_INTERVAL: begin
               interval_in = csr_wdata;
            end
            default: begin
               interval_in = interval_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff     <= 1'b0;
         out_vld_ff    <= 1'b0;
         prev_armed_ff <= 1'b0;
         prev_run_ff   <= 1'b0;
         sess_start_ff <= '0;
         sess_sec_ff   <= '0;
         run_start_ff  <= '0;
         acc_ff        <= '0;
         last_save_ff  <= '0;
         interval_ff   <= SAVE_INTERVAL_RESET;
      end else begin
         in_vld_ff     <= in_vld_in;
         out_vld_ff    <= out_vld_in;
         prev_armed_ff <= prev_armed_in;
         prev_run_ff   <= prev_run_in;
         sess_start_ff <= sess_start_in;
         sess_sec_ff   <= sess_sec_in;
         run_start_ff  <= run_start_in;
         acc_ff        <= acc_in;
         last_save_ff  <= last_save_in;
         interval_ff   <= interval_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_now_ff   <= req_time_ms;
         in_armed_ff <= req_armed;
         in_run_ff   <= req_motor_running;
      end
      if (advance) begin
         out_sess_ff   <= in_armed_ff ? sess_q : sess_sec_ff;
         out_total_ff  <= live;
         out_strobe_ff <= flush || periodic;
         out_value_ff  <= (flush || periodic) ? live : '0;
      end
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp_session_sec = out_sess_ff;
   assign rsp_total_sec   = out_total_ff;
   assign rsp_save_strobe = out_strobe_ff;
   assign rsp_save_value  = out_value_ff;

endmodule

// ----- design/mhm_checker.sv -----
// Port-level checker for the motor hour meter, bound to motor_hour_meter_unit.
`include "assert_macros.svh"

module mhm_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input mhm_pkg::sec_type rsp_session_sec,
   input mhm_pkg::sec_type rsp_total_sec,
   input logic             rsp_save_strobe,
   input mhm_pkg::sec_type rsp_save_value
);
   import mhm_pkg::*;

   // whole result payload, for the stability check
   logic [3*SEC_W:0] rsp_beat;
   assign rsp_beat = {rsp_session_sec, rsp_total_sec, rsp_save_strobe, rsp_save_value};

   // result beat holds while stalled
   `MHM_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid)
   `MHM_ASSERT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall |=> $stable(rsp_beat))
   // no save value without a strobe
   `MHM_NEVER(a_value_zero, clock, reset, rsp_valid && !rsp_save_strobe && (rsp_save_value != '0))
   // request side only backs up behind a full, stalled result register
   `MHM_ASSERT(a_stall_cause, clock, reset, req_stall |-> rsp_valid && rsp_stall)
   // result register empties out of reset
   `MHM_ASSERT(a_reset_empty, clock, 1'b0, reset |=> !rsp_valid)

endmodule

bind motor_hour_meter_unit mhm_checker u_mhm_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_session_sec (rsp_session_sec),
   .rsp_total_sec   (rsp_total_sec),
   .rsp_save_strobe (rsp_save_strobe),
   .rsp_save_value  (rsp_save_value)
);

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for motor_hour_meter_unit with its own meter predictor.
module tb_top;
   import mhm_pkg::*;

   localparam int unsigned HALF_PERIOD    = 10;
   localparam int unsigned RESET_CYCLES   = 7;
   localparam int unsigned MS_PER_SEC     = 1000;
   localparam int unsigned HOLDOFF_CYCLES = 300;
   localparam int unsigned TAIL_CYCLES    = 10;   // margin after the last reading before the verdict
   localparam int unsigned RANDOM_BEATS   = 190;  // per random phase
   localparam int unsigned PRESSURE_BEATS = 60;

   // One result beat: the meter reading for one sample.
   typedef struct packed {
      sec_type session_sec;
      sec_type total_sec;
      logic    save_strobe;
      sec_type save_value;
   } meter_reading_type;

   // ---------------------------------------------------------------------------
   // DUT signals; every input has a known value from time zero
   // ---------------------------------------------------------------------------
   logic         clock             = 1'b0;
   logic         reset             = 1'b1;
   logic         req_valid         = 1'b0;
   logic         req_stall;
   time_type     req_time_ms       = '0;
   logic         req_armed         = 1'b0;
   logic         req_motor_running = 1'b0;
   logic         rsp_valid;
   logic         rsp_stall         = 1'b0;
   sec_type      rsp_session_sec;
   sec_type      rsp_total_sec;
   logic         rsp_save_strobe;
   sec_type      rsp_save_value;
   logic         csr_we            = 1'b0;
   csr_idx_type  csr_index         = CSR_STORED_TOTAL;
   csr_data_type csr_wdata         = '0;

   motor_hour_meter_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_time_ms       (req_time_ms),
      .req_armed         (req_armed),
      .req_motor_running (req_motor_running),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_session_sec   (rsp_session_sec),
      .rsp_total_sec     (rsp_total_sec),
      .rsp_save_strobe   (rsp_save_strobe),
      .rsp_save_value    (rsp_save_value),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // ---------------------------------------------------------------------------
   // Meter predictor: its own copy of the settings and of the meter state
   // ---------------------------------------------------------------------------
   time_type mtr_interval_ms;
   logic     mtr_prev_armed;
   logic     mtr_prev_running;
   time_type mtr_session_start_ms;
   sec_type  mtr_session_sec;
   time_type mtr_run_start_ms;
   sec_type  mtr_accum_sec;
   time_type mtr_last_save_ms;

   meter_reading_type expected_readings[$];
   int unsigned       mismatch_count = 0;

   // Whole seconds between two wrapping millisecond stamps.
   function automatic sec_type whole_secs(time_type now, time_type start);
      time_type span;
      span = now - start;
      return span / MS_PER_SEC;
   endfunction

   function automatic meter_reading_type advance_meter(time_type now, logic armed, logic running);
      meter_reading_type rd;
      logic    arm_rise;
      logic    arm_fall;
      logic    flush;
      logic    periodic;
      sec_type live;
      time_type since_save;
      arm_rise = armed && !mtr_prev_armed;
      arm_fall = !armed && mtr_prev_armed;
      flush    = 1'b0;
      periodic = 1'b0;

      if (arm_rise) begin
         mtr_session_start_ms = now;
         mtr_session_sec      = '0;
      end
      if (armed)
         mtr_session_sec = whole_secs(now, mtr_session_start_ms);

      if (running && !mtr_prev_running)
         mtr_run_start_ms = now;

      // A run ends on a motor stop or a disarm; both at once count once.
      if (mtr_prev_running && (!running || arm_fall)) begin
         mtr_accum_sec    = mtr_accum_sec + whole_secs(now, mtr_run_start_ms);
         mtr_run_start_ms = running ? now : '0;
         flush            = 1'b1;
      end else if (arm_fall) begin
         flush = 1'b1;
      end
      if (flush)
         mtr_last_save_ms = now;

      live = running ? mtr_accum_sec + whole_secs(now, mtr_run_start_ms) : mtr_accum_sec;

      since_save = now - mtr_last_save_ms;
      if (running && since_save >= mtr_interval_ms) begin
         periodic         = 1'b1;
         mtr_last_save_ms = now;
      end

      mtr_prev_armed   = armed;
      mtr_prev_running = running;

      rd.session_sec = mtr_session_sec;
      rd.total_sec   = live;
      rd.save_strobe = flush || periodic;
      rd.save_value  = periodic ? live : (flush ? mtr_accum_sec : '0);
      return rd;
   endfunction

   task automatic note_mismatch(string what);
      $display("%0t ns: mismatch: %s", $realtime, what);
      mismatch_count++;
   endtask

   // ---------------------------------------------------------------------------
   // Scoreboard: checks each result beat, then predicts each accepted request
   // beat. One process, so push and pop never race within a time step.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      meter_reading_type want;
      if (reset) begin
         mtr_interval_ms      = SAVE_INTERVAL_RESET;
         mtr_prev_armed       = 1'b0;
         mtr_prev_running     = 1'b0;
         mtr_session_start_ms = '0;
         mtr_session_sec      = '0;
         mtr_run_start_ms     = '0;
         mtr_accum_sec        = '0;
         mtr_last_save_ms     = '0;
         expected_readings.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_readings.size() == 0) begin
               note_mismatch("result beat with nothing expected");
            end else begin
               want = expected_readings.pop_front();
               if (rsp_session_sec !== want.session_sec)
                  note_mismatch($sformatf("session_sec got %0d want %0d",
                                          rsp_session_sec, want.session_sec));
               if (rsp_total_sec !== want.total_sec)
                  note_mismatch($sformatf("total_sec got %0d want %0d",
                                          rsp_total_sec, want.total_sec));
               if (rsp_save_strobe !== want.save_strobe)
                  note_mismatch($sformatf("save_strobe got %b want %b",
                                          rsp_save_strobe, want.save_strobe));
               if (rsp_save_value !== want.save_value)
                  note_mismatch($sformatf("save_value got %0d want %0d",
                                          rsp_save_value, want.save_value));
            end
         end
         if (req_valid && !req_stall)
            expected_readings.push_back(advance_meter(req_time_ms, req_armed,
                                                      req_motor_running));
      end
   end

   // ---------------------------------------------------------------------------
   // Result-side stall. A long hold-off, once requested, is counted here.
   // ---------------------------------------------------------------------------
   int unsigned rsp_stall_pct   = 0;
   int unsigned holdoff_request = 0;
   int unsigned holdoff_left    = 0;

   always @(negedge clock) begin
      if (holdoff_request != 0) begin
         holdoff_left    = holdoff_request;
         holdoff_request = 0;
      end
      if (holdoff_left != 0) begin
         holdoff_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // ---------------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------------
   int unsigned sender_idle_pct = 0;
   time_type    stim_now;
   logic        stim_armed;
   logic        stim_running;

   // Called at a falling edge; returns at the falling edge after the beat is taken.
   task automatic send_beat(time_type now, logic armed, logic running);
      int unsigned gap;
      gap = ($urandom_range(99) < sender_idle_pct) ? $urandom_range(1, 3) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_time_ms       <= now;
      req_armed         <= armed;
      req_motor_running <= running;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // Idle the request side and wait until every reading has come back.
   task automatic wait_all_readings();
      req_valid <= 1'b0;
      while (expected_readings.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Loads both registers back to back; only while the block is idle.
   task automatic write_settings(sec_type stored_total, time_type interval_ms);
      csr_we    <= 1'b1;
      csr_index <= CSR_STORED_TOTAL;
      csr_wdata <= stored_total;
      @(negedge clock);
      csr_index <= CSR_SAVE_INTERVAL;
      csr_wdata <= interval_ms;
      @(negedge clock);
      csr_we <= 1'b0;
      mtr_accum_sec   = stored_total;
      mtr_interval_ms = interval_ms;
   endtask

   // Mostly plausible time steps with level toggles; some wild jumps as noise.
   task automatic next_random_sample();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 5)
         stim_now = $urandom();
      else if (pick < 10)
         stim_now = stim_now;
      else if (pick < 25)
         stim_now = stim_now + $urandom_range(0, 250000);
      else
         stim_now = stim_now + $urandom_range(1, 3000);
      if ($urandom_range(99) < 8)
         stim_armed = !stim_armed;
      if ($urandom_range(99) < 14)
         stim_running = !stim_running;
   endtask

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // Reset settings: arming, runs, periodic save at the default interval,
   // stop and disarm together, disarm with the motor still on.
   task automatic test_edges_at_default_interval();
      sender_idle_pct = 0;
      rsp_stall_pct   = 0;
      send_beat(32'd0,     1'b0, 1'b0);
      send_beat(32'd1000,  1'b1, 1'b0);   // arm
      send_beat(32'd3500,  1'b1, 1'b0);
      send_beat(32'd4000,  1'b1, 1'b1);   // motor on
      send_beat(32'd64000, 1'b1, 1'b1);   // periodic save due
      send_beat(32'd70999, 1'b1, 1'b0);   // motor stop
      send_beat(32'd71000, 1'b0, 1'b0);   // disarm, session held
      send_beat(32'd72000, 1'b0, 1'b1);   // running while disarmed
      send_beat(32'd80000, 1'b1, 1'b1);   // arm mid-run
      send_beat(32'd85000, 1'b0, 1'b1);   // disarm, motor keeps running
      send_beat(32'd86000, 1'b1, 1'b1);
      send_beat(32'd90500, 1'b0, 1'b0);   // stop and disarm in one beat
      wait_all_readings();
   endtask

   // Time wrap, interval extremes (zero, one, all ones) and a wrapping total.
   task automatic test_wrap_and_interval_extremes();
      write_settings(mtr_accum_sec, 32'd1);
      send_beat(32'hFFFF_FF00, 1'b1, 1'b1);  // arm and start just before wrap
      send_beat(32'h0000_0300, 1'b1, 1'b1);  // across the wrap
      wait_all_readings();
      write_settings(mtr_accum_sec, 32'd0);  // zero: save on every running beat
      send_beat(32'h0000_0500, 1'b0, 1'b1);  // flush and periodic together
      send_beat(32'h0000_0600, 1'b0, 1'b1);
      send_beat(32'hFFFF_FFFF, 1'b0, 1'b0);  // long run ends at the top of time
      wait_all_readings();
      write_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_beat(32'd0,         1'b1, 1'b1);
      send_beat(32'd5000,      1'b1, 1'b1);  // live total wraps
      send_beat(32'd5000,      1'b1, 1'b0);  // stored total wraps
      send_beat(32'hFFFF_FFFF, 1'b1, 1'b1);
      send_beat(32'd4999,      1'b1, 1'b1);  // exactly the full interval since save
      wait_all_readings();
   endtask

   // Random sessions under one idling mode and fresh settings.
   task automatic test_random_phase(int unsigned idle_pct, int unsigned stall_pct);
      sec_type  total;
      time_type interval;
      case ($urandom_range(2))
         0:       total = '0;
         1:       total = 32'hFFFF_FFFF - $urandom_range(0, 500);
         default: total = $urandom();
      endcase
      case ($urandom_range(5))
         0:       interval = 32'd1;
         1:       interval = 32'hFFFF_FFFF;
         2:       interval = SAVE_INTERVAL_RESET;
         3:       interval = 32'd0;
         default: interval = $urandom_range(500, 20000);
      endcase
      write_settings(total, interval);
      sender_idle_pct = idle_pct;
      rsp_stall_pct   = stall_pct;
      repeat (RANDOM_BEATS) begin
         next_random_sample();
         send_beat(stim_now, stim_armed, stim_running);
      end
      wait_all_readings();
   endtask

   // Result side held off for a long stretch while beats keep coming, so the
   // pipeline fills and the request side must stall.
   task automatic test_input_backpressure();
      sender_idle_pct = 0;
      rsp_stall_pct   = 0;
      @(posedge clock);
      holdoff_request = HOLDOFF_CYCLES;
      @(negedge clock);
      repeat (PRESSURE_BEATS) begin
         next_random_sample();
         send_beat(stim_now, stim_armed, stim_running);
      end
      wait_all_readings();
   endtask

   // ---------------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------------
   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_edges_at_default_interval();
      test_wrap_and_interval_extremes();

      stim_now     = $urandom();
      stim_armed   = 1'b0;
      stim_running = 1'b0;
      test_random_phase(0, 0);
      test_random_phase(54, 0);
      test_random_phase(0, 54);
      test_random_phase(15, 15);
      test_input_backpressure();
      test_random_phase(0, 0);

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_readings.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // Guard against a hang; far beyond the slowest correct run.
   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+design
design/mhm_pkg.sv
design/motor_hour_meter_unit.sv
design/mhm_checker.sv
test/tb_top.sv
